### rtl/trace_gap_linear_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trace gap interpolator
// Short forms for immediate-implication and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef TRACE_GAP_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TRACE_GAP_LINEAR_INTERPOLATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TGLI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TGLI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tgli_pkg.sv
// ----------------------------------------------------------------------------
// tgli_pkg
// Widths, register codes and transaction types of the trace gap interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tgli_pkg;

  localparam int TRACE_W    = 20;
  localparam int COORD_W    = 40;
  localparam int SP_W       = 32;
  localparam int SP_FRAC    = 8;

  // widest gap that is still filled
  localparam int MAX_GAP    = 32;
  localparam int DEN_W      = $clog2(MAX_GAP + 1);

  // lanes: difference of two coordinates needs one extra bit
  localparam int LANE_W     = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int DIV_STEPS  = MAG_W;
  localparam int NUM_LANES  = 3;
  localparam int LANE_X     = 0;
  localparam int LANE_Y     = 1;
  localparam int LANE_SP    = 2;

  localparam int JOB_DEPTH  = 2;
  localparam int OUT_DEPTH  = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TRACE_W;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_SP     = 2'd2;

  typedef struct packed {
    logic        [TRACE_W-1:0] trace_number;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [SP_W-1:0]    shotpoint;
    logic                      end_of_line;
  } in_item_t;

  typedef struct packed {
    logic        [TRACE_W-1:0] out_trace;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [SP_W-1:0]    out_sp;
    logic                      is_interpolated;
    logic                      gap_too_large;
    logic                      last_of_run;
  } result_t;

  // work handed from the front to the back; shotpoints already resolved
  typedef struct packed {
    logic        [TRACE_W-1:0] prev_trace;
    logic signed [COORD_W-1:0] prev_x;
    logic signed [COORD_W-1:0] prev_y;
    logic signed [SP_W-1:0]    prev_sp;
    logic        [TRACE_W-1:0] cur_trace;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic signed [SP_W-1:0]    cur_sp;
    logic        [DEN_W-1:0]   den;
    logic                      emit_prev;
    logic                      gap_big;
    logic                      do_interp;
    logic                      emit_cur;
  } job_t;

  // trace number as a Q24.8 shotpoint
  function automatic logic signed [SP_W-1:0] trace_to_sp(input logic [TRACE_W-1:0] t);
    trace_to_sp = SP_W'({t, {SP_FRAC{1'b0}}});
  endfunction

endpackage

`default_nettype wire

### rtl/tgli_fifo.sv
// ----------------------------------------------------------------------------
// tgli_fifo
// Small register queue, first word fall-through.
// ----------------------------------------------------------------------------
`default_nettype none

module tgli_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tgli_front.sv
// ----------------------------------------------------------------------------
// tgli_front
// Holds the configuration and the previous known point, classifies each
// incoming point and queues the work for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tgli_front import tgli_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  in_item_t              item,
  output logic                  full,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  job_full,
  output logic                  job_push,
  output job_t                  job
);

  logic [TRACE_W-1:0]      range_low;
  logic [TRACE_W-1:0]      range_high;
  logic                    use_sp;
  logic                    have_prev;
  logic [TRACE_W-1:0]      prev_trace;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic signed [SP_W-1:0]  prev_sp;

  logic                    accept;
  logic                    prev_in;
  logic                    cur_in;
  logic                    ascending;
  logic [TRACE_W-1:0]      gap_len;
  logic                    gap_big;

  always_comb begin
    accept    = push && !job_full;
    prev_in   = have_prev && (prev_trace >= range_low) && (prev_trace <= range_high);
    cur_in    = (item.trace_number >= range_low) && (item.trace_number <= range_high);
    ascending = item.trace_number > prev_trace;
    gap_len   = item.trace_number - prev_trace;
    gap_big   = prev_in && ascending && (gap_len > TRACE_W'(MAX_GAP));

    job.prev_trace = prev_trace;
    job.prev_x     = prev_x;
    job.prev_y     = prev_y;
    job.prev_sp    = use_sp ? prev_sp : trace_to_sp(prev_trace);
    job.cur_trace  = item.trace_number;
    job.cur_x      = item.coord_x;
    job.cur_y      = item.coord_y;
    job.cur_sp     = use_sp ? item.shotpoint : trace_to_sp(item.trace_number);
    job.den        = gap_len[DEN_W-1:0];
    job.emit_prev  = prev_in;
    job.gap_big    = gap_big;
    // a gap of one trace has nothing to fill
    job.do_interp  = prev_in && ascending && !gap_big && (gap_len >= TRACE_W'(2));
    job.emit_cur   = item.end_of_line && cur_in;

    job_push = accept && (job.emit_prev || job.emit_cur);
    full     = job_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= '1;
      use_sp     <= 1'b0;
      have_prev  <= 1'b0;
      prev_trace <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      prev_sp    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RANGE_LOW:  range_low  <= cfg_data[TRACE_W-1:0];
          REG_RANGE_HIGH: range_high <= cfg_data[TRACE_W-1:0];
          REG_USE_SP:     use_sp     <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (item.end_of_line) begin
          have_prev <= 1'b0;
        end else begin
          have_prev  <= 1'b1;
          prev_trace <= item.trace_number;
          prev_x     <= item.coord_x;
          prev_y     <= item.coord_y;
          prev_sp    <= item.shotpoint;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tgli_back.sv
// ----------------------------------------------------------------------------
// tgli_back
// Emits the held point, fills the gap by linear interpolation and emits the
// closing point. One bit-serial divider per lane gives |cur - prev| / gap;
// the points then follow by accumulating quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module tgli_back import tgli_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_empty,
  input  job_t    job_head,
  output logic    job_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {S_IDLE, S_PREV, S_DIV, S_INTERP, S_CUR} state_t;

  state_t                    state;
  job_t                      job;
  logic [CNT_W-1:0]          div_cnt;
  logic [TRACE_W-1:0]        t;
  logic [MAG_W-1:0]          dvd   [NUM_LANES];
  logic [DEN_W-1:0]          rem   [NUM_LANES];
  logic                      neg   [NUM_LANES];
  logic signed [LANE_W-1:0]  sacc  [NUM_LANES];
  logic [DEN_W-1:0]          racc  [NUM_LANES];
  logic signed [LANE_W-1:0]  step  [NUM_LANES];
  logic signed [LANE_W-1:0]  step1 [NUM_LANES];

  logic signed [LANE_W-1:0]  head_p    [NUM_LANES];
  logic signed [LANE_W-1:0]  head_c    [NUM_LANES];
  logic signed [LANE_W-1:0]  p_lane    [NUM_LANES];
  logic [MAG_W-1:0]          mag_ld    [NUM_LANES];
  logic                      neg_ld    [NUM_LANES];
  logic [DEN_W:0]            trial     [NUM_LANES];
  logic                      ge        [NUM_LANES];
  logic [DEN_W-1:0]          rem_step  [NUM_LANES];
  logic [MAG_W-1:0]          dvd_step  [NUM_LANES];
  logic [LANE_W-1:0]         uq_ext    [NUM_LANES];
  logic signed [LANE_W-1:0]  step_c    [NUM_LANES];
  logic signed [LANE_W-1:0]  step1_c   [NUM_LANES];
  logic [DEN_W:0]            r_sum     [NUM_LANES];
  logic                      carry     [NUM_LANES];
  logic [DEN_W-1:0]          r_next    [NUM_LANES];
  logic signed [LANE_W-1:0]  s_next    [NUM_LANES];
  logic signed [LANE_W-1:0]  pt        [NUM_LANES];
  logic [TRACE_W-1:0]        t_next;
  logic                      last_interp;
  logic                      res_valid;

  always_comb begin
    head_p[LANE_X]  = LANE_W'(job_head.prev_x);
    head_p[LANE_Y]  = LANE_W'(job_head.prev_y);
    head_p[LANE_SP] = LANE_W'(job_head.prev_sp);
    head_c[LANE_X]  = LANE_W'(job_head.cur_x);
    head_c[LANE_Y]  = LANE_W'(job_head.cur_y);
    head_c[LANE_SP] = LANE_W'(job_head.cur_sp);
    p_lane[LANE_X]  = LANE_W'(job.prev_x);
    p_lane[LANE_Y]  = LANE_W'(job.prev_y);
    p_lane[LANE_SP] = LANE_W'(job.prev_sp);

    for (int i = 0; i < NUM_LANES; i++) begin
      neg_ld[i] = head_c[i] < head_p[i];
      mag_ld[i] = neg_ld[i] ? MAG_W'(head_p[i] - head_c[i])
                            : MAG_W'(head_c[i] - head_p[i]);

      // restoring division, one quotient bit per cycle
      trial[i]    = {rem[i], dvd[i][MAG_W-1]};
      ge[i]       = trial[i] >= {1'b0, job.den};
      rem_step[i] = ge[i] ? DEN_W'(trial[i] - {1'b0, job.den}) : trial[i][DEN_W-1:0];
      dvd_step[i] = {dvd[i][MAG_W-2:0], ge[i]};

      // signed per-trace increment and the same with the remainder carry
      uq_ext[i]  = {1'b0, dvd[i]};
      step_c[i]  = neg[i] ? $signed(~uq_ext[i] + LANE_W'(1)) : $signed(uq_ext[i]);
      step1_c[i] = neg[i] ? $signed(~uq_ext[i]) : $signed(uq_ext[i] + LANE_W'(1));

      r_sum[i]  = {1'b0, racc[i]} + {1'b0, rem[i]};
      carry[i]  = r_sum[i] >= {1'b0, job.den};
      r_next[i] = carry[i] ? DEN_W'(r_sum[i] - {1'b0, job.den}) : r_sum[i][DEN_W-1:0];
      s_next[i] = sacc[i] + (carry[i] ? step1[i] : step[i]);

      pt[i] = p_lane[i] + sacc[i];
    end

    t_next      = t + TRACE_W'(1);
    last_interp = t_next == job.cur_trace;
  end

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    case (state)
      S_PREV: begin
        res_valid         = 1'b1;
        res.out_trace     = job.prev_trace;
        res.out_x         = job.prev_x;
        res.out_y         = job.prev_y;
        res.out_sp        = job.prev_sp;
        res.gap_too_large = job.gap_big;
        res.last_of_run   = !job.do_interp && !job.emit_cur;
      end
      S_INTERP: begin
        res_valid           = 1'b1;
        res.out_trace       = t;
        res.out_x           = pt[LANE_X][COORD_W-1:0];
        res.out_y           = pt[LANE_Y][COORD_W-1:0];
        res.out_sp          = pt[LANE_SP][SP_W-1:0];
        res.is_interpolated = 1'b1;
        res.last_of_run     = last_interp && !job.emit_cur;
      end
      S_CUR: begin
        res_valid       = 1'b1;
        res.out_trace   = job.cur_trace;
        res.out_x       = job.cur_x;
        res.out_y       = job.cur_y;
        res.out_sp      = job.cur_sp;
        res.last_of_run = 1'b1;
      end
      default: ;
    endcase
    res_push = res_valid && !res_full;
    job_pop  = (state == S_IDLE) && !job_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      // a new job reloads the dividers instead
      if (div_cnt != '0 && !job_pop) begin
        div_cnt <= div_cnt - CNT_W'(1);
        dvd     <= dvd_step;
        rem     <= rem_step;
      end
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            job     <= job_head;
            div_cnt <= CNT_W'(DIV_STEPS);
            for (int i = 0; i < NUM_LANES; i++) begin
              dvd[i] <= mag_ld[i];
              rem[i] <= '0;
              neg[i] <= neg_ld[i];
            end
            state <= job_head.emit_prev ? S_PREV : S_CUR;
          end
        end
        S_PREV: begin
          if (!res_full) begin
            if (job.do_interp) begin
              state <= S_DIV;
            end else if (job.emit_cur) begin
              state <= S_CUR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            sacc  <= step_c;
            step  <= step_c;
            step1 <= step1_c;
            racc  <= rem;
            t     <= job.prev_trace + TRACE_W'(1);
            state <= S_INTERP;
          end
        end
        S_INTERP: begin
          if (!res_full) begin
            sacc <= s_next;
            racc <= r_next;
            t    <= t_next;
            if (last_interp) begin
              state <= job.emit_cur ? S_CUR : S_IDLE;
            end
          end
        end
        S_CUR: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/trace_gap_linear_interpolator.sv
// ----------------------------------------------------------------------------
// trace_gap_linear_interpolator
// Known points of a survey line go in on a push/full queue port; the held
// point, linearly interpolated points for every missing trace number, and on
// end of line the closing point come out on an empty/pop queue port. A point
// that closes a gap of n traces (2 <= n <= MAX_GAP) passes the back end in
// order: it takes the work, emits the held point, waits for the bit-serial
// dividers that form |cur - prev| / n for X, Y and shotpoint, emits the
// filled points and, when it also ends the line, the closing point. Points
// that need no interpolation skip the dividers.
// A two-deep work queue lets the front accept the next points while the back
// is still busy; a two-deep result queue lets the back run ahead of pop.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trace_gap_linear_interpolator_assert.svh"

module trace_gap_linear_interpolator import tgli_pkg::*; #(
  parameter int JOB_QUEUE_DEPTH = JOB_DEPTH,
  parameter int OUT_QUEUE_DEPTH = OUT_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  in_item_t              item,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                    job_push;
  logic                    job_full;
  logic                    job_empty;
  logic                    job_pop;
  job_t                    job_in;
  logic [$bits(job_t)-1:0] job_rdata;
  job_t                    job_head;
  logic                    res_push;
  logic                    res_full;
  result_t                 res;
  logic [$bits(result_t)-1:0] res_rdata;

  tgli_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (job_in)
  );

  tgli_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  assign job_head = job_t'(job_rdata);

  tgli_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  tgli_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = result_t'(res_rdata);

  `TGLI_ASSERT_IMPLY(a_res_no_overflow, clk, rst, res_push, !res_full, "result written into full queue")
  `TGLI_ASSERT_IMPLY(a_job_no_overflow, clk, rst, job_push, !job_full, "work written into full queue")
  `TGLI_ASSERT_IMPLY(a_gap_flag_known, clk, rst, res_push && res.gap_too_large, !res.is_interpolated, "gap flag on interpolated point")
  `TGLI_ASSERT_NEXT(a_pop_busy, clk, rst, job_pop, !job_pop, "back end took two jobs in a row")

endmodule

`default_nettype wire

### verif/tb_trace_gap_linear_interpolator.sv
// ----------------------------------------------------------------------------
// tb_trace_gap_linear_interpolator
// Self-checking bench for the trace gap interpolator. A directed table covers
// the field extremes, lines that start with end of line, repeated and
// descending trace numbers, a gap one past the fill limit and one right at it,
// and window, empty-window and use_sp changes. Then random survey lines follow
// under several register settings. Each point is run through a local gap-fill
// model at the moment it is accepted. Popped points are compared field by
// field with the oldest predicted point. Both queue sides idle at random.
// ----------------------------------------------------------------------------
module tb_trace_gap_linear_interpolator;
  import tgli_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 120;
  localparam int MAX_REPORTS   = 30;

  localparam logic signed [COORD_W-1:0] C_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 40'sh80_0000_0000;
  localparam logic        [TRACE_W-1:0] T_TOP = 20'hF_FFFF;

  typedef enum logic {ROW_POINT, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    in_item_t            pt;
    bit                  typed;
    result_t             expv;
    logic [TRACE_W-1:0]  lo;
    logic [TRACE_W-1:0]  hi;
    bit                  usp;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  in_item_t              item = '0;
  logic                  full;
  logic                  empty;
  logic                  pop = 1'b0;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_RANGE_LOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  trace_gap_linear_interpolator uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // gap-fill model state and register copies
  logic [TRACE_W-1:0] win_lo = '0;
  logic [TRACE_W-1:0] win_hi = T_TOP;
  bit                 sp_from_input = 1'b0;
  in_item_t           held_pt = '0;
  bit                 held_valid = 1'b0;

  result_t            pending_points[$];
  result_t            tail;
  bit                 have_tail;
  bit                 keep_results;

  stim_row_t          dir_tab[$];
  logic [COORD_W-1:0] last_x = '0;
  logic [COORD_W-1:0] last_y = '0;
  logic [SP_W-1:0]    last_sp = '0;
  bit                 send_burst = 1'b0;
  bit                 recv_burst = 1'b0;

  int fail_count = 0;
  int points_in = 0;
  int points_out = 0;
  int interp_out = 0;
  int gap_flags = 0;
  int cfg_sets = 0;
  int cycles = 0;

  function automatic result_t mk_res(input logic [TRACE_W-1:0] t,
                                     input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y,
                                     input logic [SP_W-1:0] sp,
                                     input bit interp, input bit gap, input bit last);
    result_t r;
    r.out_trace = t;
    r.out_x = x;
    r.out_y = y;
    r.out_sp = sp;
    r.is_interpolated = interp;
    r.gap_too_large = gap;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic in_item_t mk_pt(input logic [TRACE_W-1:0] t,
                                     input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y,
                                     input logic [SP_W-1:0] sp, input bit eol);
    in_item_t p;
    p.trace_number = t;
    p.coord_x = x;
    p.coord_y = y;
    p.shotpoint = sp;
    p.end_of_line = eol;
    return p;
  endfunction

  function automatic stim_row_t point_row(input in_item_t p);
    stim_row_t r;
    r.kind = ROW_POINT;
    r.pt = p;
    r.typed = 1'b0;
    r.expv = '0;
    r.lo = '0;
    r.hi = '0;
    r.usp = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input in_item_t p, input result_t e);
    stim_row_t r;
    r = point_row(p);
    r.typed = 1'b1;
    r.expv = e;
    return r;
  endfunction

  function automatic stim_row_t config_row(input logic [TRACE_W-1:0] lo,
                                           input logic [TRACE_W-1:0] hi, input bit usp);
    stim_row_t r;
    r = point_row('0);
    r.kind = ROW_CONFIG;
    r.lo = lo;
    r.hi = hi;
    r.usp = usp;
    return r;
  endfunction

  function automatic bit in_window(input logic [TRACE_W-1:0] t);
    return t >= win_lo && t <= win_hi;
  endfunction

  // prev + (cur - prev) * num / den, quotient truncated toward zero
  function automatic longint blend(input longint p, input longint c,
                                   input longint num, input longint den);
    return p + ((c - p) * num) / den;
  endfunction

  // the last point of a step is held back so last_of_run can be set on it
  task automatic queue_point(input result_t r);
    if (have_tail && keep_results) pending_points.push_back(tail);
    tail = r;
    have_tail = 1'b1;
  endtask

  task automatic interpolate_point(input in_item_t pt, input bit keep);
    logic [TRACE_W-1:0] t0;
    logic [TRACE_W-1:0] t1;
    longint x0, y0, x1, y1, sp0, sp1, den, sp;
    bit big;
    keep_results = keep;
    have_tail = 1'b0;
    t1 = pt.trace_number;
    if (held_valid && in_window(held_pt.trace_number)) begin
      t0 = held_pt.trace_number;
      x0 = longint'($signed(held_pt.coord_x));
      y0 = longint'($signed(held_pt.coord_y));
      x1 = longint'($signed(pt.coord_x));
      y1 = longint'($signed(pt.coord_y));
      sp0 = sp_from_input ? longint'($signed(held_pt.shotpoint)) : longint'(t0) << SP_FRAC;
      sp1 = sp_from_input ? longint'($signed(pt.shotpoint)) : longint'(t1) << SP_FRAC;
      big = (t1 > t0) && ((t1 - t0) > MAX_GAP);
      queue_point(mk_res(t0, held_pt.coord_x, held_pt.coord_y, SP_W'(sp0),
                         1'b0, big, 1'b0));
      if (t1 > t0 && !big) begin
        den = longint'(t1 - t0);
        for (longint k = 1; k < den; k++) begin
          sp = sp_from_input ? blend(sp0, sp1, k, den) : (longint'(t0) + k) << SP_FRAC;
          queue_point(mk_res(TRACE_W'(longint'(t0) + k), COORD_W'(blend(x0, x1, k, den)),
                             COORD_W'(blend(y0, y1, k, den)), SP_W'(sp),
                             1'b1, 1'b0, 1'b0));
        end
      end
    end
    if (pt.end_of_line) begin
      if (in_window(t1))
        queue_point(mk_res(t1, pt.coord_x, pt.coord_y,
                           sp_from_input ? pt.shotpoint : SP_W'(longint'(t1) << SP_FRAC),
                           1'b0, 1'b0, 1'b0));
      held_valid = 1'b0;
    end else begin
      held_pt = pt;
      held_valid = 1'b1;
    end
    if (have_tail && keep) begin
      tail.last_of_run = 1'b1;
      pending_points.push_back(tail);
    end
    have_tail = 1'b0;
  endtask

  // called at a falling edge; leaves push high so back-to-back points stay possible
  task automatic send_item(input in_item_t pt, input bit typed, input result_t expv);
    int gap;
    if ($urandom_range(0, 24) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item = pt;
    push = 1'b1;
    do @(posedge clk); while (full);
    interpolate_point(pt, !typed);
    if (typed) pending_points.push_back(expv);
    points_in++;
    @(negedge clk);
  endtask

  // registers change only once every predicted point has been popped
  task automatic set_config(input logic [TRACE_W-1:0] lo, input logic [TRACE_W-1:0] hi,
                            input bit usp);
    push = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = REG_RANGE_LOW;
    cfg_data = lo;
    @(negedge clk);
    cfg_index = REG_RANGE_HIGH;
    cfg_data = hi;
    @(negedge clk);
    cfg_index = REG_USE_SP;
    cfg_data = CFG_DATA_W'(usp);
    @(negedge clk);
    cfg_we = 1'b0;
    win_lo = lo;
    win_hi = hi;
    sp_from_input = usp;
    cfg_sets++;
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(input logic [COORD_W-1:0] prev);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return C_MAX;
    if (r == 1) return C_MIN;
    if (r < 6) return COORD_W'({$urandom, $urandom});
    return prev + COORD_W'($urandom_range(0, 8191)) - COORD_W'(4096);
  endfunction

  task automatic make_point(input logic [TRACE_W-1:0] tr, input bit eol,
                            output in_item_t pt);
    pt.trace_number = tr;
    pt.coord_x = rand_coord(last_x);
    pt.coord_y = rand_coord(last_y);
    pt.shotpoint = ($urandom_range(0, 1) == 1) ? SP_W'($urandom)
                   : last_sp + SP_W'($urandom_range(0, 2047)) - SP_W'(1024);
    pt.end_of_line = eol;
    last_x = pt.coord_x;
    last_y = pt.coord_y;
    last_sp = pt.shotpoint;
  endtask

  // random survey lines near the window, mostly ascending with fillable gaps
  task automatic run_phase(input int n_items, input logic [TRACE_W-1:0] lo,
                           input logic [TRACE_W-1:0] hi, input bit usp);
    int sent, len, r;
    logic [TRACE_W-1:0] tr;
    in_item_t pt;
    set_config(lo, hi, usp);
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      tr = ($urandom_range(0, 3) == 0) ? TRACE_W'($urandom)
           : lo - TRACE_W'(40) + TRACE_W'($urandom_range(0, 80));
      for (int k = 0; k < len && sent < n_items; k++) begin
        make_point(tr, (k == len - 1) && ($urandom_range(0, 9) != 0), pt);
        send_item(pt, 1'b0, '0);
        sent++;
        r = $urandom_range(0, 99);
        if (r < 55) tr = tr + TRACE_W'($urandom_range(1, 6));
        else if (r < 80) tr = tr + TRACE_W'($urandom_range(7, MAX_GAP));
        else if (r < 88) tr = tr + TRACE_W'($urandom_range(MAX_GAP + 1, MAX_GAP + 40));
        else if (r < 94) tr = tr;
        else tr = tr - TRACE_W'($urandom_range(1, 20));
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] expv,
                               input logic [63:0] gotv);
    if (expv !== gotv) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, gotv);
    end
  endtask

  // result side
  initial begin
    int stall;
    result_t e;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 24) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      points_out++;
      if (result.is_interpolated) interp_out++;
      if (result.gap_too_large) gap_flags++;
      if (pending_points.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none, actual %0h",
                   $time, result);
      end else begin
        e = pending_points.pop_front();
        compare_field("out_trace", 64'(e.out_trace), 64'(result.out_trace));
        compare_field("out_x", 64'(e.out_x), 64'(result.out_x));
        compare_field("out_y", 64'(e.out_y), 64'(result.out_y));
        compare_field("out_sp", 64'(e.out_sp), 64'(result.out_sp));
        compare_field("is_interpolated", 64'(e.is_interpolated),
                      64'(result.is_interpolated));
        compare_field("gap_too_large", 64'(e.gap_too_large), 64'(result.gap_too_large));
        compare_field("last_of_run", 64'(e.last_of_run), 64'(result.last_of_run));
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d transactions still expected", $time,
               pending_points.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [TRACE_W-1:0] lo;
    // after reset: first points of a line that carry end of line, field extremes
    dir_tab.push_back(checked_row(mk_pt(20'd0, C_MIN, C_MAX, 32'h7FFF_FFFF, 1'b1),
                                  mk_res(20'd0, C_MIN, C_MAX, 32'd0, 1'b0, 1'b0, 1'b1)));
    dir_tab.push_back(checked_row(mk_pt(T_TOP, C_MAX, C_MIN, 32'h8000_0000, 1'b1),
                                  mk_res(T_TOP, C_MAX, C_MIN, 32'h0FFF_FF00,
                                         1'b0, 1'b0, 1'b1)));
    // fill, repeated trace, descending trace, gap one past the limit, gap at it
    dir_tab.push_back(point_row(mk_pt(20'd10, 0, 0, 5, 1'b0)));
    dir_tab.push_back(point_row(mk_pt(20'd14, 400, -400, 9, 1'b0)));
    dir_tab.push_back(point_row(mk_pt(20'd14, 1000, 2000, 0, 1'b0)));
    dir_tab.push_back(point_row(mk_pt(20'd12, -300, 77, 0, 1'b0)));
    dir_tab.push_back(checked_row(mk_pt(20'd45, 5, 6, 0, 1'b0),
                                  mk_res(20'd12, -300, 77, 32'h0000_0C00,
                                         1'b0, 1'b1, 1'b1)));
    dir_tab.push_back(point_row(mk_pt(20'd77, 40'sh12_3456_7800, -9999, 0, 1'b0)));
    dir_tab.push_back(point_row(mk_pt(20'd78, 1, 2, 3, 1'b1)));
    // given shotpoints, extremes across a gap, truncation of negative steps
    dir_tab.push_back(config_row(20'd0, T_TOP, 1'b1));
    dir_tab.push_back(point_row(mk_pt(20'd100, C_MAX, C_MIN, 32'h7FFF_FFFF, 1'b0)));
    dir_tab.push_back(point_row(mk_pt(20'd103, C_MIN, C_MAX, 32'h8000_0000, 1'b1)));
    dir_tab.push_back(point_row(mk_pt(20'd200, 0, 0, 0, 1'b0)));
    dir_tab.push_back(point_row(mk_pt(20'd203, -2, 2, -1, 1'b0)));
    // narrow window entered with a point held out of range, use_sp dropped mid line
    dir_tab.push_back(config_row(20'd205, 20'd210, 1'b0));
    dir_tab.push_back(point_row(mk_pt(20'd206, 50, 60, 0, 1'b0)));
    dir_tab.push_back(point_row(mk_pt(20'd209, 80, 30, 0, 1'b0)));
    dir_tab.push_back(point_row(mk_pt(20'd215, -80, 90, 0, 1'b1)));
    // empty window, then a single-trace window
    dir_tab.push_back(config_row(20'd300, 20'd100, 1'b1));
    dir_tab.push_back(point_row(mk_pt(20'd150, 1, 1, 1, 1'b0)));
    dir_tab.push_back(point_row(mk_pt(20'd160, 2, 2, 2, 1'b1)));
    dir_tab.push_back(config_row(20'd7, 20'd7, 1'b0));
    dir_tab.push_back(point_row(mk_pt(20'd7, 11, 12, 13, 1'b1)));

    repeat (7) @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CONFIG)
        set_config(dir_tab[i].lo, dir_tab[i].hi, dir_tab[i].usp);
      else
        send_item(dir_tab[i].pt, dir_tab[i].typed, dir_tab[i].expv);
    end

    run_phase(70, 20'd0, T_TOP, 1'b1);
    lo = TRACE_W'($urandom_range(1000, 20'hF_F000));
    run_phase(70, lo, lo + TRACE_W'($urandom_range(0, 300)), 1'b0);
    run_phase(50, T_TOP, T_TOP, 1'b1);
    run_phase(20, 20'd500, 20'd400, 1'($urandom_range(0, 1)));
    run_phase(70, 20'd0, TRACE_W'($urandom_range(40, 400)), 1'b0);

    push = 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d known points under %0d register settings.", points_in, cfg_sets);
    $display("Popped %0d points: %0d interpolated, %0d with an unfilled gap.",
             points_out, interp_out, gap_flags);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
